>>> rtl/core/stepper_step_pulse_generator_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the step pulse generator
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef STEPPER_STEP_PULSE_GENERATOR_UNIT_MACROS_SVH
`define STEPPER_STEP_PULSE_GENERATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every edge outside reset
`define SSPG_ASSERT_HOLDS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define SSPG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SSPG_ASSERT_HOLDS(label, prop, msg)
`define SSPG_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> rtl/core/sspg_pkg.sv
// ---------------------------------------------------------------------------
// Step pulse generator package
// Sizes, command codes, transaction types and the period conversion.
// ---------------------------------------------------------------------------
package sspg_pkg;

	localparam int NUM_MOTORS   = 2;
	localparam int COUNTER_BITS = 16;
	localparam int PERIOD_W     = 18;
	localparam int MODE_W       = 2;
	localparam int ID_W         = 2;
	localparam int MASK_W       = 2;
	localparam int CFG_IDX_W    = 1;
	// motors beyond the mask fields are not reported
	localparam int MASK_MOTORS  = (NUM_MOTORS < MASK_W) ? NUM_MOTORS : MASK_W;

	// half-period count = (us * 25 + 32) >> 6
	localparam int HALF_MUL   = 25;
	localparam int HALF_ROUND = 32;
	localparam int HALF_SHIFT = 6;
	localparam int PROD_W     = PERIOD_W + 5;
	localparam int HALF_RAW_W = PROD_W - HALF_SHIFT;

	localparam logic [COUNTER_BITS-1:0] COUNTER_MAX = '1;

	localparam logic [PERIOD_W-1:0] MIN_PERIOD_RESET = PERIOD_W'(100);
	localparam logic [PERIOD_W-1:0] MAX_PERIOD_RESET = PERIOD_W'(167770);

	// command codes
	localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RUN  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_STOP = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD = 1'b1;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [ID_W-1:0]     motor_id;
		logic [PERIOD_W-1:0] req_period;
		logic                direction;
	} cmd_t;

	typedef struct packed {
		logic [MASK_W-1:0]   step_levels;
		logic [MASK_W-1:0]   directions;
		logic [MASK_W-1:0]   running_mask;
		logic [PERIOD_W-1:0] period_readback;
	} res_t;

	// period in microseconds to half-period timer counts, saturating
	function automatic logic [COUNTER_BITS-1:0] half_count(input logic [PERIOD_W-1:0] us);
		logic [PROD_W-1:0]     prod;
		logic [HALF_RAW_W-1:0] raw;
		prod = (PROD_W'(us) << 4) + (PROD_W'(us) << 3) + PROD_W'(us) + PROD_W'(HALF_ROUND);
		raw  = prod[PROD_W-1:HALF_SHIFT];
		if (raw > HALF_RAW_W'(COUNTER_MAX)) begin
			return COUNTER_MAX;
		end
		return raw[COUNTER_BITS-1:0];
	endfunction

endpackage

>>> rtl/core/stepper_step_pulse_generator_unit.sv
// ---------------------------------------------------------------------------
// Stepper step pulse generator
// Output-compare channels that toggle step pins, on a counter advanced by tick commands.
// ---------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  cmd      in         cmd_valid/cmd_stall  cmd (tick, run or stop)
//  res      out        res_valid/res_stall  res (levels, directions, mask, period)
//  cfg      in         cfg_we               cfg_index, cfg_data
//
//  One transaction a cycle while the result is not stalled; a command goes from
//  the input register to the result register, and these two set the rate: every
//  update of counter and channel state is done combinationally between them.
//  A stalled result holds the input register, then stalls cmd.
//  Reset clears the counter, all channel state and loads the period limits.
// ---------------------------------------------------------------------------
module stepper_step_pulse_generator_unit
	import sspg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  cmd_t                 cmd,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_t                 res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PERIOD_W-1:0]  cfg_data
);

`include "stepper_step_pulse_generator_unit_macros.svh"

	// configuration
	logic [PERIOD_W-1:0] min_period_q;
	logic [PERIOD_W-1:0] max_period_q;

	// input register and result register
	logic valid_s1;
	cmd_t cmd_s1;
	logic res_valid_q;
	res_t res_q;
	logic proc;

	// channel state
	logic [COUNTER_BITS-1:0] counter_q, counter_d, counter_inc;
	logic [COUNTER_BITS-1:0] compare_q [NUM_MOTORS];
	logic [COUNTER_BITS-1:0] compare_d [NUM_MOTORS];
	logic [COUNTER_BITS-1:0] half_q    [NUM_MOTORS];
	logic [COUNTER_BITS-1:0] half_d    [NUM_MOTORS];
	logic [PERIOD_W-1:0]     stored_period_q [NUM_MOTORS];
	logic [PERIOD_W-1:0]     stored_period_d [NUM_MOTORS];
	logic [NUM_MOTORS-1:0]   running_q, running_d;
	logic [NUM_MOTORS-1:0]   dir_q, dir_d;
	logic [NUM_MOTORS-1:0]   level_q, level_d;

	logic [PERIOD_W-1:0]     period_clamped;
	logic [COUNTER_BITS-1:0] half_new;
	logic [COUNTER_BITS-1:0] start_delay;
	res_t                    res_d;

	// handshake: the input register moves whenever the result register can take
	assign proc      = valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = valid_s1 && !proc;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_period_q <= MIN_PERIOD_RESET;
			max_period_q <= MAX_PERIOD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_PERIOD: min_period_q <= cfg_data;
				CFG_MAX_PERIOD: max_period_q <= cfg_data;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
	end

	// period clamp and conversions
	always_comb begin
		if (cmd_s1.req_period < min_period_q) begin
			period_clamped = min_period_q;
		end else if (cmd_s1.req_period > max_period_q) begin
			period_clamped = max_period_q;
		end else begin
			period_clamped = cmd_s1.req_period;
		end
		half_new    = half_count(period_clamped);
		start_delay = half_count(min_period_q);
		// first match must lie in the future
		if (start_delay == '0) begin
			start_delay = COUNTER_BITS'(1);
		end
	end

	// next channel state for the transaction in the input register
	always_comb begin
		counter_inc     = counter_q + COUNTER_BITS'(1);
		counter_d       = counter_q;
		compare_d       = compare_q;
		half_d          = half_q;
		stored_period_d = stored_period_q;
		running_d       = running_q;
		dir_d           = dir_q;
		level_d         = level_q;
		unique case (cmd_s1.mode)
			MODE_TICK: begin
				counter_d = counter_inc;
				for (int i = 0; i < NUM_MOTORS; i++) begin
					if (compare_q[i] == counter_inc) begin
						if (running_q[i]) begin
							level_d[i]   = ~level_q[i];
							compare_d[i] = compare_q[i] + half_q[i];
						end else begin
							level_d[i] = 1'b0;
						end
					end
				end
			end
			MODE_RUN: begin
				for (int i = 0; i < NUM_MOTORS; i++) begin
					if (cmd_s1.motor_id == ID_W'(i)) begin
						stored_period_d[i] = period_clamped;
						half_d[i]          = half_new;
						dir_d[i]           = cmd_s1.direction;
						if (!running_q[i]) begin
							compare_d[i] = counter_q + start_delay;
							running_d[i] = 1'b1;
						end
					end
				end
			end
			MODE_STOP: begin
				for (int i = 0; i < NUM_MOTORS; i++) begin
					if (cmd_s1.motor_id == ID_W'(i)) begin
						running_d[i]       = 1'b0;
						stored_period_d[i] = '0;
						half_d[i]          = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// result assembly from the updated state
	always_comb begin
		res_d = '0;
		for (int i = 0; i < MASK_MOTORS; i++) begin
			res_d.step_levels[i]  = level_d[i];
			res_d.directions[i]   = dir_d[i];
			res_d.running_mask[i] = running_d[i];
		end
		for (int i = 0; i < NUM_MOTORS; i++) begin
			if (cmd_s1.motor_id == ID_W'(i)) begin
				res_d.period_readback = stored_period_d[i];
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q       <= '0;
			compare_q       <= '{default: '0};
			half_q          <= '{default: '0};
			stored_period_q <= '{default: '0};
			running_q       <= '0;
			dir_q           <= '0;
			level_q         <= '0;
		end else if (proc) begin
			counter_q       <= counter_d;
			compare_q       <= compare_d;
			half_q          <= half_d;
			stored_period_q <= stored_period_d;
			running_q       <= running_d;
			dir_q           <= dir_d;
			level_q         <= level_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (proc) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			res_q <= res_d;
		end
	end

	// checks
	`SSPG_ASSERT_NEXT(a_tick_advances, proc && cmd_s1.mode == MODE_TICK, counter_q == $past(counter_q) + COUNTER_BITS'(1), "tick did not advance the counter")
	`SSPG_ASSERT_NEXT(a_stop_clears_run, proc && cmd_s1.mode == MODE_STOP && cmd_s1.motor_id == ID_W'(0), !running_q[0], "stop left motor running")
	`SSPG_ASSERT_HOLDS(a_idle_no_period, running_q[0] || stored_period_q[0] == '0, "idle motor holds a period")

endmodule
